// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by sjfq_ctrl and sjfq_dp
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every rising edge outside reset
`define ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hw/rtl/sjfq_pkg.sv =====
`default_nettype none
package sjfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W    = 16;
    localparam int STATE_W = 2;
    localparam int NICE_W  = 3;
    localparam int TICK_W  = 16;
    localparam int OCC_W   = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0]  key;
        logic [ID_W-1:0]    id;
        logic [STATE_W-1:0] st;
        logic [NICE_W-1:0]  nice;
        logic [TICK_W-1:0]  used;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sjfq_ctrl.sv =====
`default_nettype none
module sjfq_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output sjfq_pkg::ctrl_cmd_t     cmd
);
    import sjfq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.load     = 1'b0;
        cmd.exec     = 1'b0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // wait until the output register can take the result
                if (out_free) begin
                    cmd.exec     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`include "assert_macros.svh"
    `ASSERT_RST(a_load_then_exec, aclk, aresetn, cmd.load |=> state_reg == ST_EXEC)
    `ASSERT_RST(a_exec_fills_out, aclk, aresetn, cmd.exec |=> m_valid_reg)
    `ASSERT_ALWAYS(a_no_overlap, aclk, !(cmd.load && cmd.exec))

endmodule
`default_nettype wire

// ===== hw/rtl/sjfq_dp.sv =====
`default_nettype none
module sjfq_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire sjfq_pkg::ctrl_cmd_t           cmd,
    input  wire logic                          in_cmd,
    input  wire logic [sjfq_pkg::ID_W-1:0]     in_id,
    input  wire logic [sjfq_pkg::STATE_W-1:0]  in_state,
    input  wire logic [sjfq_pkg::NICE_W-1:0]   in_nice,
    input  wire logic [sjfq_pkg::TICK_W-1:0]   in_used,
    input  wire logic [sjfq_pkg::TICK_W-1:0]   in_need,
    output logic                               rec_valid,
    output logic [sjfq_pkg::ID_W-1:0]          rec_id,
    output logic [sjfq_pkg::STATE_W-1:0]       rec_state,
    output logic [sjfq_pkg::NICE_W-1:0]        rec_nice,
    output logic [sjfq_pkg::TICK_W-1:0]        rec_used,
    output logic [sjfq_pkg::TICK_W-1:0]        rec_need,
    output logic                               is_empty,
    output logic                               dropped,
    output logic [sjfq_pkg::OCC_W-1:0]         occupancy
);
    import sjfq_pkg::*;

    // latched input beat
    logic              op_reg;
    entry_t            new_reg;

    entry_t            store_reg [QUEUE_DEPTH];
    entry_t            ins_store [QUEUE_DEPTH];
    entry_t            pop_store [QUEUE_DEPTH];
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [QUEUE_DEPTH-1:0] gt;
    logic              full, empty, do_ins, do_pop;

    entry_t            rec_reg;
    logic              rec_valid_reg, empty_reg, dropped_reg;
    logic [OCC_W-1:0]  occ_reg;

    assign full   = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign empty  = (fill_reg == '0);
    assign do_ins = (op_reg == CMD_INSERT) && !full;
    assign do_pop = (op_reg == CMD_POP) && !empty;

    // slots past the fill level count as greater, so a record with no larger key in the queue lands at the tail
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            gt[i] = (CNT_W'(i) >= fill_reg) || (store_reg[i].key > new_reg.key);
        end
    end

    always_comb begin
        ins_store[0] = gt[0] ? new_reg : store_reg[0];
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if (!gt[i]) begin
                ins_store[i] = store_reg[i];
            end else if (gt[i-1]) begin
                ins_store[i] = store_reg[i-1];
            end else begin
                ins_store[i] = new_reg;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            pop_store[i] = store_reg[i+1];
        end
        pop_store[QUEUE_DEPTH-1] = store_reg[QUEUE_DEPTH-1];
    end

    always_comb begin
        fill_next = fill_reg;
        if (do_ins) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.exec) begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= in_cmd;
            new_reg.key  <= in_need;
            new_reg.id   <= in_id;
            new_reg.st   <= in_state;
            new_reg.nice <= in_nice;
            new_reg.used <= in_used;
        end
        if (cmd.exec) begin
            if (do_ins) begin
                store_reg <= ins_store;
            end else if (do_pop) begin
                store_reg <= pop_store;
            end
            rec_valid_reg <= do_pop;
            rec_reg       <= do_pop ? store_reg[0] : '0;
            dropped_reg   <= (op_reg == CMD_INSERT) && full;
            empty_reg     <= (fill_next == '0);
            occ_reg       <= OCC_W'(fill_next);
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec_id    = rec_reg.id;
    assign rec_state = rec_reg.st;
    assign rec_nice  = rec_reg.nice;
    assign rec_used  = rec_reg.used;
    assign rec_need  = rec_reg.key;
    assign is_empty  = empty_reg;
    assign dropped   = dropped_reg;
    assign occupancy = occ_reg;

`include "assert_macros.svh"
    `ASSERT_RST(a_fill_bound, aclk, aresetn, fill_reg <= CNT_W'(QUEUE_DEPTH))
    `ASSERT_RST(a_ins_grows, aclk, aresetn, (cmd.exec && do_ins) |=> fill_reg == $past(fill_reg) + 1'b1)
    `ASSERT_RST(a_pop_head, aclk, aresetn, (cmd.exec && do_pop) |=> rec_reg.key == $past(store_reg[0].key))
    `ASSERT_RST(a_head_sorted, aclk, aresetn, (fill_reg >= CNT_W'(2)) |-> store_reg[0].key <= store_reg[1].key)

endmodule
`default_nettype wire

// ===== hw/rtl/shortest_job_first_queue.sv =====
// channel   dir  tdata (low bit up)                                   tuser
// s_axis    in   proc_id, proc_state, nice_level, used_ticks,         cmd
//                need_ticks (53 bits, padded to 56)
// m_axis    out  rec_id, rec_state, rec_nice, rec_used, rec_need,      rec_valid
//                is_empty, dropped, occupancy (60 bits, padded to 64)
//
// every command passes through the controller states ST_IDLE, which latches the beat, and ST_EXEC,
// which does the parallel compare across all entries and the insert-shift or pop-shift of the store
// the result sits in an output register, so a new beat is taken while it waits
// when a result is still held, the execute cycle waits for m_axis_tready
// aresetn (sync, active low) empties the queue; entry contents are not cleared
`default_nettype none
module shortest_job_first_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // proc_id[15:0], proc_state[17:16], nice_level[20:18], used_ticks[36:21],
    // need_ticks[52:37]
    input  wire logic [55:0] s_axis_tdata,
    // cmd[0]
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // rec_id[15:0], rec_state[17:16], rec_nice[20:18], rec_used[36:21],
    // rec_need[52:37], is_empty[53], dropped[54], occupancy[59:55]
    output logic [63:0]      m_axis_tdata,
    // rec_valid[0]
    output logic [0:0]       m_axis_tuser
);
    import sjfq_pkg::*;

    ctrl_cmd_t            cmd;
    logic                 rec_valid, is_empty, dropped;
    logic [ID_W-1:0]      rec_id;
    logic [STATE_W-1:0]   rec_state;
    logic [NICE_W-1:0]    rec_nice;
    logic [TICK_W-1:0]    rec_used, rec_need;
    logic [OCC_W-1:0]     occupancy;

    sjfq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd)
    );

    sjfq_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_cmd    (s_axis_tuser[0]),
        .in_id     (s_axis_tdata[15:0]),
        .in_state  (s_axis_tdata[17:16]),
        .in_nice   (s_axis_tdata[20:18]),
        .in_used   (s_axis_tdata[36:21]),
        .in_need   (s_axis_tdata[52:37]),
        .rec_valid (rec_valid),
        .rec_id    (rec_id),
        .rec_state (rec_state),
        .rec_nice  (rec_nice),
        .rec_used  (rec_used),
        .rec_need  (rec_need),
        .is_empty  (is_empty),
        .dropped   (dropped),
        .occupancy (occupancy)
    );

    assign m_axis_tdata = {4'b0, occupancy, dropped, is_empty, rec_need, rec_used,
                           rec_nice, rec_state, rec_id};
    assign m_axis_tuser = rec_valid;

endmodule
`default_nettype wire
